/* src/ffba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and command/status structs for the block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int NUM_UNITS   = 256;
    localparam int BRICK_BYTES = 32;
    localparam int UW          = $clog2(NUM_UNITS);
    localparam int BSH         = $clog2(BRICK_BYTES);
    localparam int BYTES_W     = 13;
    localparam int REQ_W       = 16;
    localparam int GAP_W       = 8;

    localparam logic [UW-1:0] TAIL_UNIT = UW'(NUM_UNITS - 1);
    localparam logic [REQ_W:0] MAX_BYTES = (REQ_W + 1)'((NUM_UNITS - 2) * BRICK_BYTES);

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_RD,     // read node n
        ST_A_CHK,    // evaluate node n
        ST_A_SPL1,   // split: write node n
        ST_A_SPL2,   // split: write new node
        ST_A_SPL3,   // split: prev of next
        ST_A_WHOLE,  // grant whole gap
        ST_R_RD,     // walk chain looking for node
        ST_R_CHK,
        ST_R_NB_RD,  // read next and prev nodes
        ST_R_NB_CHK,
        ST_R_POST_RD,
        ST_R_POST_CHK,
        ST_R_W1,
        ST_R_W2,
        ST_R_W3,
        ST_AF_RD,    // read node 0 for all_free
        ST_AF_CHK,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;       // latch input item
        logic    rd;         // issue read at addr_sel
        logic [2:0] addr_sel;   // 0:n 1:nx 2:pv 3:post 4:zero
        logic    step;       // n <= next of current read
        logic    lat_nx;     // latch next/prev of current read as nx/pv
        logic    lat_pv;     // latch current read used as pv info
        logic    lat_post;   // post <= next of read
        logic    wr;
        logic [3:0] wsel;    // write command code
        logic    gap_dec;
        logic    gap_inc;
        logic    set_ok;
        logic    set_grant;
        logic    set_whole;
        logic    lat_af;
        logic    clr_grant;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic func;
        logic too_big;
        logic gap_zero;
        logic n_at_tail;
        logic n_is_node;
        logic node_zero;
        logic fit;
        logic split;
        logic used;
        logic nx_free;
        logic pv_free;
        logic steps_done;
    } stat_t;

    // write commands
    localparam logic [3:0] W_SPLIT_N    = 4'd0;
    localparam logic [3:0] W_SPLIT_NN   = 4'd1;
    localparam logic [3:0] W_SPLIT_NX   = 4'd2;
    localparam logic [3:0] W_WHOLE_N    = 4'd3;
    localparam logic [3:0] W_FREE_NODE  = 4'd4;
    localparam logic [3:0] W_BOTH_PV    = 4'd5;
    localparam logic [3:0] W_BOTH_POST  = 4'd6;
    localparam logic [3:0] W_NEXT_NODE  = 4'd7;
    localparam logic [3:0] W_NEXT_POST  = 4'd8;
    localparam logic [3:0] W_PREV_PV    = 4'd9;
    localparam logic [3:0] W_PREV_NX    = 4'd10;

    localparam logic [2:0] A_N    = 3'd0;
    localparam logic [2:0] A_NX   = 3'd1;
    localparam logic [2:0] A_PV   = 3'd2;
    localparam logic [2:0] A_POST = 3'd3;
    localparam logic [2:0] A_ZERO = 3'd4;

endpackage
`default_nettype wire

/* src/ffba_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// Node memory, walk pointers, size arithmetic and result registers.
// ----------------------------------------------------------------------------
module ffba_datapath (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire logic                 in_func,
    input  wire logic [15:0]          in_bytes,
    input  wire logic [7:0]           in_unit,
    input  wire ffba_pkg::cmd_t       cmd,
    output ffba_pkg::stat_t           stat,
    output logic                      res_ok,
    output logic [7:0]                res_unit,
    output logic [12:0]               res_bytes,
    output logic                      res_all_free
);
    import ffba_pkg::*;

    localparam int MW = 2 * UW + 1;

    // entry: {used, next, prev}. Valid bits give the reset contents.
    logic [MW-1:0] mem [NUM_UNITS];
    logic [NUM_UNITS-1:0] vld_reg;
    logic [MW-1:0] rd_raw_reg;
    logic          rd_vld_reg;
    logic [UW-1:0] rd_addr_reg;

    logic          func_reg;
    logic [16:0]   bytes_reg;
    logic [UW-1:0] node_reg;   // target node for release
    logic [UW-1:0] n_reg, nx_reg, pv_reg, post_reg;
    logic          nx_used_reg, pv_used_reg;
    logic [UW:0]   want_reg;   // units wanted
    logic [UW:0]   steps_reg;
    logic [GAP_W-1:0] gap_reg;
    logic          ok_reg, af_reg;
    logic [7:0]    unit_reg;
    logic [12:0]   gbytes_reg;

    logic [UW-1:0] raddr;
    logic          r_used;
    logic [UW-1:0] r_next, r_prev;
    logic [UW-1:0] w_addr;
    logic [MW-1:0] w_data, w_old;
    logic [UW:0]   size_u;

    // reset view of an entry
    function automatic logic [MW-1:0] rst_entry(input logic [UW-1:0] a);
        logic [MW-1:0] e;
        e = '0;
        if (a == TAIL_UNIT) e[MW-1] = 1'b1;
        if (a == '0) e[2*UW-1:UW] = TAIL_UNIT;
        return e;
    endfunction

    always_comb begin
        unique case (cmd.addr_sel)
            A_NX:    raddr = nx_reg;
            A_PV:    raddr = pv_reg;
            A_ZERO:  raddr = '0;
            A_POST:  raddr = post_reg;
            default: raddr = n_reg;
        endcase
    end

    logic [MW-1:0] rd_ent;
    assign rd_ent = rd_vld_reg ? rd_raw_reg : rst_entry(rd_addr_reg);
    assign r_used = rd_ent[MW-1];
    assign r_next = rd_ent[2*UW-1:UW];
    assign r_prev = rd_ent[UW-1:0];
    assign size_u = (r_next > n_reg) ? ({1'b0, r_next} - {1'b0, n_reg} - 1'b1) : '0;

    // write address/data; writes read-modify the shadow of the known fields
    logic [UW-1:0] nn;
    assign nn = n_reg + want_reg[UW-1:0] + 1'b1;
    logic [2:0] wm;  // mask: used, next, prev
    logic [MW-1:0] wv;
    always_comb begin
        w_addr = n_reg; wv = '0; wm = '0;
        unique case (cmd.wsel)
            W_SPLIT_N:   begin w_addr = n_reg;   wv = {1'b1, nn, {UW{1'b0}}};        wm = 3'b110; end
            W_SPLIT_NN:  begin w_addr = nn;      wv = {1'b0, nx_reg, n_reg};         wm = 3'b111; end
            W_SPLIT_NX:  begin w_addr = nx_reg;  wv = {1'b0, {UW{1'b0}}, nn};        wm = 3'b001; end
            W_WHOLE_N:   begin w_addr = n_reg;   wv = {1'b1, {2*UW{1'b0}}};          wm = 3'b100; end
            W_FREE_NODE: begin w_addr = node_reg; wv = '0;                           wm = 3'b100; end
            W_BOTH_PV:   begin w_addr = pv_reg;  wv = {1'b0, post_reg, {UW{1'b0}}};  wm = 3'b010; end
            W_BOTH_POST: begin w_addr = post_reg; wv = {1'b0, {UW{1'b0}}, pv_reg};   wm = 3'b001; end
            W_NEXT_NODE: begin w_addr = node_reg; wv = {1'b0, post_reg, pv_reg};     wm = 3'b111; end
            W_NEXT_POST: begin w_addr = post_reg; wv = {1'b0, {UW{1'b0}}, node_reg}; wm = 3'b001; end
            W_PREV_PV:   begin w_addr = pv_reg;  wv = {1'b0, nx_reg, {UW{1'b0}}};    wm = 3'b010; end
            W_PREV_NX:   begin w_addr = nx_reg;  wv = {1'b0, {UW{1'b0}}, pv_reg};    wm = 3'b001; end
            default:     begin w_addr = n_reg;   wv = '0; wm = '0; end
        endcase
    end
    // partial writes merge with the entry from the controller's most recent read
    assign w_old = rd_ent;
    assign w_data = {wm[2] ? wv[MW-1] : w_old[MW-1],
                     wm[1] ? wv[2*UW-1:UW] : w_old[2*UW-1:UW],
                     wm[0] ? wv[UW-1:0] : w_old[UW-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_raw_reg  <= mem[raddr];
            rd_addr_reg <= raddr;
        end
        if (cmd.wr) mem[w_addr] <= w_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            gap_reg    <= GAP_W'(1);
        end else begin
            // a read returns the old entry, so it goes with the old valid bit
            if (cmd.rd) rd_vld_reg <= vld_reg[raddr];
            if (cmd.wr) vld_reg[w_addr] <= 1'b1;
            if (cmd.gap_dec) gap_reg <= gap_reg - 1'b1;
            else if (cmd.gap_inc) gap_reg <= gap_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= in_func;
            bytes_reg <= {1'b0, in_bytes};
            node_reg  <= in_unit[UW-1:0] - 1'b1;
            n_reg     <= '0;
            steps_reg <= '0;
            want_reg  <= (in_bytes <= 16'(BRICK_BYTES)) ? (UW+1)'(1)
                       : (UW+1)'((17'(in_bytes) + 17'(BRICK_BYTES - 1)) >> BSH);
        end
        if (cmd.step) begin
            n_reg     <= r_next;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.lat_nx) begin
            nx_reg      <= r_next;
            pv_reg      <= r_prev;
        end
        if (cmd.lat_pv) pv_used_reg <= r_used;
        if (cmd.lat_post) begin
            nx_used_reg <= r_used;
            post_reg    <= r_next;
        end
        if (cmd.clr_grant) begin
            ok_reg <= 1'b0; unit_reg <= '0; gbytes_reg <= '0;
        end
        if (cmd.set_ok) ok_reg <= 1'b1;
        if (cmd.set_grant) begin
            unit_reg   <= 8'(n_reg + 1'b1);
            gbytes_reg <= cmd.set_whole ? (13'(size_u) << BSH) : (13'(want_reg) << BSH);
        end
        if (cmd.lat_af) af_reg <= !r_used && r_next == TAIL_UNIT;
    end

    logic [UW:0] spare;
    assign spare = size_u - want_reg;
    assign stat.func       = func_reg;
    assign stat.too_big    = bytes_reg > MAX_BYTES;
    assign stat.gap_zero   = gap_reg == '0;
    assign stat.n_at_tail  = n_reg == TAIL_UNIT;
    assign stat.n_is_node  = n_reg == node_reg;
    assign stat.node_zero  = node_reg == '0;
    assign stat.fit        = !r_used && size_u >= want_reg;
    assign stat.split      = spare >= (UW+1)'(2);
    assign stat.used       = r_used;
    assign stat.nx_free    = nx_reg != TAIL_UNIT && !nx_used_reg;
    assign stat.pv_free    = !pv_used_reg;
    assign stat.steps_done = steps_reg == (UW+1)'(NUM_UNITS);

    assign res_ok       = ok_reg;
    assign res_unit     = unit_reg;
    assign res_bytes    = gbytes_reg;
    assign res_all_free = af_reg;

    // a split always lands the new node strictly inside the chosen gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr && cmd.wsel == W_SPLIT_NN) |-> (nn > n_reg && nn < nx_reg))
        else $error("split node outside gap");
    // gap counter moves one way at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.gap_dec && cmd.gap_inc)) else $error("gap counter conflict");
    // a grant is never larger than the largest possible gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ok_reg) && !func_reg |-> gbytes_reg <= 13'((NUM_UNITS - 2) * BRICK_BYTES))
        else $error("grant too big");
endmodule
`default_nettype wire

/* src/ffba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for acquire walk, release search and merge, and result handshake.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire ffba_pkg::stat_t stat,
    output ffba_pkg::cmd_t       cmd
);
    import ffba_pkg::*;

    state_t state_reg, state_next;
    logic   both_reg, both_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            both_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            both_reg  <= both_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        both_next  = both_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_A_RD;
            ST_A_RD: begin
                if (stat.func == FUNC_RELEASE) state_next = ST_R_RD;
                else if (stat.gap_zero || stat.too_big) state_next = ST_AF_RD;
                else if (stat.n_at_tail || stat.steps_done) state_next = ST_AF_RD;
                else state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (stat.fit) state_next = stat.split ? ST_A_SPL1 : ST_A_WHOLE;
                else state_next = ST_A_RD;
            end
            ST_A_SPL1:  state_next = ST_A_SPL2;
            ST_A_SPL2:  state_next = ST_A_SPL3;
            ST_A_SPL3:  state_next = ST_AF_RD;
            ST_A_WHOLE: state_next = ST_AF_RD;
            ST_R_RD: begin
                if (stat.n_at_tail || stat.steps_done) state_next = ST_AF_RD;
                else state_next = ST_R_CHK;
            end
            ST_R_CHK: begin
                if (!stat.n_is_node) state_next = ST_R_RD;
                else if (!stat.used) state_next = ST_AF_RD;
                else state_next = ST_R_NB_RD;
            end
            ST_R_NB_RD:  state_next = ST_R_NB_CHK;
            ST_R_NB_CHK: state_next = ST_R_POST_RD;
            ST_R_POST_RD: state_next = ST_R_POST_CHK;
            ST_R_POST_CHK: begin
                both_next  = stat.nx_free && stat.pv_free && !stat.node_zero;
                state_next = ST_R_W1;
            end
            ST_R_W1: state_next = ST_R_W2;
            ST_R_W2: state_next = ST_R_W3;
            ST_R_W3: state_next = ST_AF_RD;
            ST_AF_RD:  state_next = ST_AF_CHK;
            ST_AF_CHK: state_next = ST_DONE;
            ST_DONE:   if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic nxf, pvf;
    assign nxf = stat.nx_free;
    assign pvf = stat.pv_free && !stat.node_zero;

    always_comb begin
        cmd      = '0;
        cmd.addr_sel = A_N;
        cmd.wsel = W_WHOLE_N;
        s_ready  = state_reg == ST_IDLE;
        m_valid  = state_reg == ST_DONE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                cmd.clr_grant = s_valid;
            end
            ST_A_RD:  cmd.rd = 1'b1;
            ST_A_CHK: begin
                if (stat.fit) begin
                    cmd.set_ok = 1'b1; cmd.set_grant = 1'b1;
                    cmd.set_whole = !stat.split;
                    cmd.lat_nx = 1'b1;
                end else cmd.step = 1'b1;
            end
            ST_A_SPL1: begin
                cmd.wr = 1'b1; cmd.wsel = W_SPLIT_N;
                cmd.rd = 1'b1; cmd.addr_sel = A_NX;
            end
            ST_A_SPL2: begin
                cmd.wr = 1'b1; cmd.wsel = W_SPLIT_NN;
                cmd.rd = 1'b1; cmd.addr_sel = A_NX;
            end
            ST_A_SPL3:  begin cmd.wr = 1'b1; cmd.wsel = W_SPLIT_NX; end
            ST_A_WHOLE: begin cmd.wr = 1'b1; cmd.wsel = W_WHOLE_N; cmd.gap_dec = 1'b1; end
            ST_R_RD:  cmd.rd = 1'b1;
            ST_R_CHK: begin
                if (!stat.n_is_node) cmd.step = 1'b1;
                else if (stat.used) cmd.lat_nx = 1'b1;
            end
            ST_R_NB_RD:  begin cmd.rd = 1'b1; cmd.addr_sel = A_PV; end
            ST_R_NB_CHK: begin cmd.lat_pv = 1'b1; cmd.rd = 1'b1; cmd.addr_sel = A_NX; end
            ST_R_POST_RD: cmd.lat_post = 1'b1;
            ST_R_POST_CHK: begin
                cmd.set_ok = 1'b1;
                cmd.rd = 1'b1; cmd.addr_sel = A_N;  // n_reg equals node here
            end
            ST_R_W1: begin
                cmd.wr = 1'b1; cmd.wsel = W_FREE_NODE;
                cmd.rd = 1'b1; cmd.addr_sel = (nxf && !both_reg) ? A_N : A_PV;
            end
            ST_R_W2: begin
                cmd.rd = 1'b1;
                if (both_reg) begin
                    cmd.wr = 1'b1; cmd.wsel = W_BOTH_PV; cmd.addr_sel = A_POST;
                end else if (nxf) begin
                    cmd.wr = 1'b1; cmd.wsel = W_NEXT_NODE; cmd.addr_sel = A_POST;
                end else if (pvf) begin
                    cmd.wr = 1'b1; cmd.wsel = W_PREV_PV; cmd.addr_sel = A_NX;
                end
            end
            ST_R_W3: begin
                if (both_reg) begin
                    cmd.wr = 1'b1; cmd.wsel = W_BOTH_POST; cmd.gap_dec = 1'b1;
                end else if (nxf) begin
                    cmd.wr = 1'b1; cmd.wsel = W_NEXT_POST;
                end else if (pvf) begin
                    cmd.wr = 1'b1; cmd.wsel = W_PREV_NX;
                end else cmd.gap_inc = 1'b1;
            end
            ST_AF_RD:  begin cmd.rd = 1'b1; cmd.addr_sel = A_ZERO; end
            ST_AF_CHK: cmd.lat_af = 1'b1;
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AF_CHK) |=> m_valid) else $error("missing result");
endmodule
`default_nettype wire

/* src/first_fit_block_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit boundary-tag allocator over one page of brick-sized units.
// ----------------------------------------------------------------------------
// One item at a time: s_ready is high only while idle, from the cycle after the
// result has been taken. An acquire reads and checks each node visited, then
// splits the chosen gap (write node, new node, prev of next) or takes it whole,
// then samples the page state; a miss walks the chain and then samples the
// page state. A request that is too large, or no gap at all, goes straight to
// the page state sample. A release walks to the node, reads its neighbors and
// relinks; an unknown block is searched for until the walk ends, an already
// free one stops at the node, and both then sample the page state.
// The walk is set by the node memory, read once per node. No clearing pass:
// per-entry valid bits give the reset page.
module first_fit_block_allocator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_func,
    input  wire  [15:0] s_request_bytes,
    input  wire  [7:0]  s_block_unit,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_ok,
    output logic [7:0]  m_granted_unit,
    output logic [12:0] m_granted_bytes,
    output logic        m_all_free
);
    import ffba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ffba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    ffba_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_func(s_func), .in_bytes(s_request_bytes), .in_unit(s_block_unit),
        .cmd(cmd), .stat(stat),
        .res_ok(m_ok), .res_unit(m_granted_unit),
        .res_bytes(m_granted_bytes), .res_all_free(m_all_free)
    );
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_block_allocator: a directed run over the
// corner cases, then random acquire/release traffic with idle gaps on both
// channels, checked item by item against an in-bench allocator model.
// ----------------------------------------------------------------------------
module tb;
    import ffba_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [7:0]  unit;
        logic [12:0] bytes;
        logic        all_free;
    } alloc_result_t;

    class alloc_scoreboard;
        logic            used [NUM_UNITS];
        logic [7:0]      nxt  [NUM_UNITS];
        logic [7:0]      prv  [NUM_UNITS];
        logic [7:0]      gaps;
        alloc_result_t   pending_q [$];
        int              errors;
        int              checked;
        int              grants;
        int              frees;

        function new();
            for (int i = 0; i < NUM_UNITS; i++) begin
                used[i] = 1'b0;
                nxt[i]  = '0;
                prv[i]  = '0;
            end
            used[TAIL_UNIT] = 1'b1;
            nxt[0]          = TAIL_UNIT;
            gaps            = 8'd1;
            errors = 0; checked = 0; grants = 0; frees = 0;
        endfunction

        function bit try_acquire(int req, output int unit, output int bytes);
            int want, n, nx, sz, spare, nn;
            unit = 0; bytes = 0;
            if (gaps == 0 || req > int'(MAX_BYTES)) return 1'b0;
            want = (req <= BRICK_BYTES) ? BRICK_BYTES
                 : ((req + BRICK_BYTES - 1) / BRICK_BYTES) * BRICK_BYTES;
            n = 0;
            for (int s = 0; s < NUM_UNITS && n < int'(TAIL_UNIT); s++) begin
                nx = int'(nxt[n]);
                sz = ((nx > n) ? nx - n - 1 : 0) * BRICK_BYTES;
                if (!used[n] && sz >= want) begin
                    spare = (sz - want) / BRICK_BYTES;
                    used[n] = 1'b1;
                    if (spare >= 2) begin
                        nn = n + 1 + want / BRICK_BYTES;
                        nxt[n] = 8'(nn); prv[nn] = 8'(n); nxt[nn] = 8'(nx); prv[nx] = 8'(nn);
                        used[nn] = 1'b0;
                    end else begin
                        want = sz;
                        gaps = gaps - 8'd1;
                    end
                    unit = n + 1; bytes = want;
                    return 1'b1;
                end
                n = nx;
            end
            return 1'b0;
        endfunction

        function bit try_release(int bu);
            int node, n, nx, pv, post;
            bit found, fn, fp;
            found = 1'b0;
            if (bu == 0) return 1'b0;
            node = bu - 1;
            n = 0;
            for (int s = 0; s < NUM_UNITS && n < int'(TAIL_UNIT); s++) begin
                if (n == node) begin
                    found = 1'b1;
                    break;
                end
                n = int'(nxt[n]);
            end
            if (!found || !used[node]) return 1'b0;
            nx = int'(nxt[node]);
            fn = (nx < int'(TAIL_UNIT)) && !used[nx];
            pv = (node != 0) ? int'(prv[node]) : 0;
            fp = (node != 0) && !used[pv];
            used[node] = 1'b0;
            if (fn && fp) begin
                post = int'(nxt[nx]); nxt[pv] = 8'(post); prv[post] = 8'(pv);
                gaps = gaps - 8'd1;
            end else if (fn) begin
                post = int'(nxt[nx]); nxt[node] = 8'(post); prv[post] = 8'(node);
            end else if (fp) begin
                nxt[pv] = 8'(nx); prv[nx] = 8'(pv);
            end else begin
                gaps = gaps + 8'd1;
            end
            return 1'b1;
        endfunction

        // Called on each accepted input item; returns the predicted result.
        function alloc_result_t note_item(logic func, logic [15:0] req, logic [7:0] bu);
            alloc_result_t r;
            int u, b;
            r = '0;
            if (func == FUNC_ACQUIRE) begin
                r.ok = try_acquire(int'(req), u, b);
                r.unit = 8'(u); r.bytes = 13'(b);
                if (r.ok) grants++;
            end else begin
                r.ok = try_release(int'(bu));
                if (r.ok) frees++;
            end
            r.all_free = !used[0] && nxt[0] == TAIL_UNIT;
            pending_q.push_back(r);
            return r;
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = pending_q.pop_front();
            checked++;
            if (got.ok !== exp.ok || got.unit !== exp.unit || got.bytes !== exp.bytes ||
                got.all_free !== exp.all_free) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d ok/unit/bytes/af: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             checked, exp.ok, exp.unit, exp.bytes, exp.all_free,
                             got.ok, got.unit, got.bytes, got.all_free);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 6000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = FUNC_ACQUIRE;
    logic [15:0] s_request_bytes = '0;
    logic [7:0]  s_block_unit = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [7:0]  m_granted_unit;
    logic [12:0] m_granted_bytes;
    logic        m_all_free;

    alloc_scoreboard sb = new();
    int  cycles = 0;
    bit  no_idle = 0;
    int  live_q [$];

    first_fit_block_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_request_bytes(s_request_bytes), .s_block_unit(s_block_unit),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_granted_unit(m_granted_unit), .m_granted_bytes(m_granted_bytes),
        .m_all_free(m_all_free)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[first_fit_block_allocator] ERROR");
            $finish;
        end
    end

    task automatic send_item(logic func, logic [15:0] req, logic [7:0] bu);
        int gap;
        alloc_result_t p;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_request_bytes <= req;
        s_block_unit    <= bu;
        do @(posedge aclk); while (!s_ready);
        p = sb.note_item(func, req, bu);
        // keep a list of blocks we hold so releases mostly hit real blocks
        if (p.ok && func == FUNC_ACQUIRE) live_q.push_back(int'(p.unit));
        if (p.ok && func == FUNC_RELEASE)
            foreach (live_q[i]) if (live_q[i] == int'(bu)) begin
                live_q.delete(i);
                break;
            end
    endtask

    task automatic acquire(int req);
        send_item(FUNC_ACQUIRE, 16'(req), 8'($urandom));
    endtask

    task automatic release_block(int bu);
        send_item(FUNC_RELEASE, 16'($urandom), 8'(bu));
    endtask

    // result side: random stalls before each item
    initial begin : result_sink
        int stall;
        alloc_result_t got;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.ok = m_ok; got.unit = m_granted_unit;
            got.bytes = m_granted_bytes; got.all_free = m_all_free;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int sel, req, idx;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        acquire(0);                 // zero -> one brick, unit 1
        acquire(33);                // rounds to two bricks, unit 3
        acquire(32);                // unit 6
        release_block(0);           // unknown block
        release_block(200);         // not on chain
        release_block(3);           // no free neighbor
        release_block(3);           // already free
        release_block(1);           // merges with free block after
        release_block(6);           // merges both sides, page empty again
        acquire(8129);              // too large
        acquire(65535);
        acquire(8128);              // whole page, no gaps left
        acquire(1);                 // no gap
        release_block(1);
        acquire(8064);              // split leaving two spare units
        acquire(32);                // takes the one-unit remainder whole
        release_block(1);
        release_block(254);         // merges with free block before
        acquire(8096);              // one spare unit: whole gap granted
        release_block(1);
        live_q.delete();

        for (int i = 0; i < 1850; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == 900) begin
                s_valid <= 1'b0;
                wait (sb.pending_q.size() == 0);
                @(posedge aclk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      req = $urandom_range(0, 256);
                else if (sel < 90) req = $urandom_range(0, 2048);
                else if (sel < 97) req = $urandom_range(0, 8128);
                else               req = $urandom_range(0, 65535);
                acquire(req);
            end else if (sel < 94 && live_q.size() > 0) begin
                idx = $urandom_range(0, live_q.size() - 1);
                release_block(live_q[idx]);
            end else begin
                release_block($urandom_range(0, 255));
            end
        end
        s_valid <= 1'b0;

        wait (sb.pending_q.size() == 0);
        repeat (50) @(posedge aclk);
        $display("checked %0d results: %0d blocks granted, %0d released",
                 sb.checked, sb.grants, sb.frees);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[first_fit_block_allocator] OK");
        end else begin
            $display("%0d failures", sb.errors + sb.pending_q.size());
            $display("[first_fit_block_allocator] ERROR");
        end
        $finish;
    end
endmodule
